/* hdl/brob_pkg.sv */
`default_nettype none

package brob_pkg;

   localparam int SLOT_FIELD_W = 6;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 25;
   localparam int DIV_DIGITS   = 8;   // 32-bit sequence number, four bits per step
   localparam int DIV_CNT_W    = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_SLOTS_IN_USE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_BYTES   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXTERNAL_MODE = 2'd2;

   localparam logic [SLOT_FIELD_W-1:0] SLOTS_IN_USE_RESET = 6'd32;
   localparam logic [CSR_DATA_W-1:0]   BLOCK_BYTES_RESET  = 25'd65536;

   localparam logic KIND_STATUS  = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_SLOT_BUSY = 3'd1;
   localparam logic [2:0] STATUS_TOO_LONG  = 3'd2;
   localparam logic [2:0] STATUS_NULL_BUF  = 3'd3;
   localparam logic [2:0] STATUS_CAP_SHORT = 3'd4;

   typedef struct packed {
      logic [31:0] seq_number;
      logic [31:0] byte_length;
      logic [47:0] buffer_addr;
      logic [31:0] buffer_room;
      logic [31:0] user_tag;
   } req_type;

   typedef struct packed {
      logic                    kind;
      logic [2:0]              status;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [31:0]             out_length;
      logic [47:0]             location;
      logic [31:0]             out_tag;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] length;
      logic [47:0] addr;
      logic [31:0] tag;
   } entry_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic check;
      logic emit_status;
      logic drain_read;
      logic emit_release;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic release_pending;
      logic release_more;
   } stat_type;

endpackage

`default_nettype wire

/* hdl/brob_ctrl.sv */
`default_nettype none

module brob_ctrl
   import brob_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   output logic          busy,
   output logic          rsp_valid,
   output cmd_type       cmd,
   input  wire stat_type stat
);

   typedef enum logic [5:0] {
      ST_IDLE       = 6'b000001,
      ST_DIVIDE     = 6'b000010,
      ST_CHECK      = 6'b000100,
      ST_STATUS     = 6'b001000,
      ST_DRAIN_READ = 6'b010000,
      ST_DRAIN_OUT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = ST_STATUS;
         end
         ST_STATUS: begin
            cmd.emit_status = 1'b1;
            state_in = stat.release_pending ? ST_DRAIN_READ : ST_IDLE;
         end
         ST_DRAIN_READ: begin
            cmd.drain_read = 1'b1;
            state_in       = ST_DRAIN_OUT;
         end
         ST_DRAIN_OUT: begin
            cmd.emit_release = 1'b1;
            state_in = stat.release_more ? ST_DRAIN_READ : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = cmd.emit_status | cmd.emit_release;

endmodule

`default_nettype wire

/* hdl/brob_dpath.sv */
`default_nettype none

module brob_dpath
   import brob_pkg::*;
#(
   parameter int SLOTS = 63
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire req_type                 req_data,
   output rsp_type                      rsp_data,
   input  wire logic                    csr_valid,
   input  wire logic [CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_data,
   input  wire cmd_type                 cmd,
   output stat_type                     stat
);

   localparam int SLOT_W = $clog2(SLOTS);
   localparam logic [SLOT_FIELD_W-1:0] SLOTS_MAX = SLOT_FIELD_W'(SLOTS);

   logic [SLOT_FIELD_W-1:0] slots_in_use_ff;
   logic [CSR_DATA_W-1:0]   block_bytes_ff;
   logic                    external_mode_ff;

   req_type                 req_ff;
   logic [31:0]             seq_sh_ff, seq_sh_in;
   logic [SLOT_FIELD_W-1:0] rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]    div_cnt_ff;
   logic [2:0]              status_ff, status_in;
   logic [SLOT_W-1:0]       ptr_ff;
   logic [SLOTS-1:0]        full_ff;
   logic [47:0]             loc_ff;
   entry_type               rd_ff;
   entry_type               mem [SLOTS];

   logic [SLOT_FIELD_W-1:0] n_active;
   logic [SLOT_W-1:0]       idx;
   logic [SLOT_W-1:0]       ptr_nx;
   logic [SLOT_FIELD_W-1:0] ptr_inc;
   logic                    status_ok;
   logic [SLOT_FIELD_W+CSR_DATA_W-1:0] loc_prod;

   always_comb begin
      if (slots_in_use_ff == '0) begin
         n_active = SLOT_FIELD_W'(1);
      end else if (slots_in_use_ff > SLOTS_MAX) begin
         n_active = SLOTS_MAX;
      end else begin
         n_active = slots_in_use_ff;
      end
   end

   // Restoring remainder, four quotient bits per cycle. The partial
   // remainder stays below the modulus, so one subtract per bit suffices.
   always_comb begin
      logic [SLOT_FIELD_W:0] t;
      logic [SLOT_FIELD_W-1:0] r;
      logic [31:0] sh;
      r  = rem_ff;
      sh = seq_sh_ff;
      for (int i = 0; i < 4; i++) begin
         t  = {r, sh[31]};
         sh = {sh[30:0], 1'b0};
         if (t >= {1'b0, n_active}) begin
            t = t - {1'b0, n_active};
         end
         r = t[SLOT_FIELD_W-1:0];
      end
      rem_in    = r;
      seq_sh_in = sh;
   end

   assign idx       = rem_ff[SLOT_W-1:0];
   assign status_ok = (status_ff == STATUS_OK);
   assign ptr_inc   = SLOT_FIELD_W'(ptr_ff) + SLOT_FIELD_W'(1);
   assign ptr_nx    = (ptr_inc == n_active) ? '0 : ptr_inc[SLOT_W-1:0];
   assign loc_prod  = SLOT_FIELD_W'(ptr_ff) * block_bytes_ff;

   always_comb begin
      if (full_ff[idx]) begin
         status_in = STATUS_SLOT_BUSY;
      end else if (external_mode_ff) begin
         if (req_ff.buffer_addr == '0) begin
            status_in = STATUS_NULL_BUF;
         end else if (req_ff.buffer_room < req_ff.byte_length) begin
            status_in = STATUS_CAP_SHORT;
         end else begin
            status_in = STATUS_OK;
         end
      end else begin
         if (req_ff.byte_length > 32'(block_bytes_ff)) begin
            status_in = STATUS_TOO_LONG;
         end else if (req_ff.buffer_addr == '0) begin
            status_in = STATUS_NULL_BUF;
         end else begin
            status_in = STATUS_OK;
         end
      end
   end

   assign stat.div_done        = (div_cnt_ff == DIV_CNT_W'(DIV_DIGITS - 1));
   assign stat.release_pending = full_ff[ptr_ff] | (status_ok & (idx == ptr_ff));
   assign stat.release_more    = full_ff[ptr_nx] & (ptr_nx != ptr_ff);

   always_comb begin
      rsp_data = '0;
      if (cmd.emit_release) begin
         rsp_data.kind       = KIND_RELEASE;
         rsp_data.status     = STATUS_OK;
         rsp_data.slot       = SLOT_FIELD_W'(ptr_ff);
         rsp_data.out_length = rd_ff.length;
         rsp_data.location   = external_mode_ff ? rd_ff.addr : loc_ff;
         rsp_data.out_tag    = external_mode_ff ? rd_ff.tag : '0;
         rsp_data.last       = ~stat.release_more;
      end else begin
         rsp_data.kind   = KIND_STATUS;
         rsp_data.status = status_ff;
         rsp_data.slot   = rem_ff;
         rsp_data.last   = ~stat.release_pending;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_in_use_ff  <= SLOTS_IN_USE_RESET;
         block_bytes_ff   <= BLOCK_BYTES_RESET;
         external_mode_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SLOTS_IN_USE:  slots_in_use_ff  <= csr_data[SLOT_FIELD_W-1:0];
            CSR_BLOCK_BYTES:   block_bytes_ff   <= csr_data;
            CSR_EXTERNAL_MODE: external_mode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff     <= '0;
         full_ff    <= '0;
         div_cnt_ff <= '0;
      end else begin
         if (cmd.load) begin
            div_cnt_ff <= '0;
         end else if (cmd.div_step) begin
            div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
         end
         // The pointer may sit past a shrunken slot count; it restarts at zero.
         if (cmd.check && (SLOT_FIELD_W'(ptr_ff) >= n_active)) begin
            ptr_ff <= '0;
         end
         if (cmd.emit_status && status_ok) begin
            full_ff[idx] <= 1'b1;
         end
         if (cmd.emit_release) begin
            full_ff[ptr_ff] <= 1'b0;
            ptr_ff          <= ptr_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff    <= req_data;
         seq_sh_ff <= req_data.seq_number;
         rem_ff    <= '0;
      end else if (cmd.div_step) begin
         seq_sh_ff <= seq_sh_in;
         rem_ff    <= rem_in;
      end
      if (cmd.check) begin
         status_ff <= status_in;
      end
      if (cmd.drain_read) begin
         loc_ff <= 48'(loc_prod);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_status && status_ok) begin
         mem[idx] <= '{length: req_ff.byte_length,
                       addr:   req_ff.buffer_addr,
                       tag:    req_ff.user_tag};
      end
      if (cmd.drain_read) begin
         rd_ff <= mem[ptr_ff];
      end
   end

endmodule

`default_nettype wire

/* hdl/block_reorder_buffer_core.sv */
// The status result follows the start transfer after the divide, check and status states;
// the sequence number is reduced modulo the slot count four bits per cycle.
// Each released block follows in turn (slot memory read, then output).
// A new descriptor is taken only when idle, once every block released by the last is out.
// Synchronous reset restores the register defaults and empties every slot.
// The receiver cannot stall: each result is on rsp_data for one cycle only.
`default_nettype none

module block_reorder_buffer_core
   import brob_pkg::*;
#(
   parameter int SLOTS = 63
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire req_type                req_data,
   output logic                        rsp_valid,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   brob_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   brob_dpath #(
      .SLOTS (SLOTS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

`default_nettype wire
